FILE: hw/rtl/filled_circle_span_generator_assert.svh
// assertion macros for the filled circle span generator
// depends on nothing; define NO_ASSERTIONS to compile them out
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define FCSG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fcsg assertion failed");
// property checked on every clock edge, reset included
`define FCSG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fcsg assertion failed");
`else
`define FCSG_ASSERT(lbl, clk, rstn, prop)
`define FCSG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/fcsg_pkg.sv
// shared types and constants for the filled circle span generator
// depends on nothing
package fcsg_pkg;

  localparam int WindowWidth  = 1024;
  localparam int WindowHeight = 1024;
  localparam int MaxRadius    = 20;
  localparam int ErrDivisor   = 16;
  localparam int ErrShift     = $clog2(ErrDivisor);
  localparam int MaxIters     = 16;
  localparam int IterW        = $clog2(MaxIters);

  localparam int InDataW  = 56;
  localparam int OutDataW = 56;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [1:0] {
    PH_ROW_PLUS_INNER,
    PH_ROW_MINUS_INNER,
    PH_ROW_PLUS_OUTER,
    PH_ROW_MINUS_OUTER
  } phase_e;

endpackage

FILE: hw/rtl/filled_circle_span_generator.sv
// filled circle span generator: midpoint circle iteration emitting clipped spans
// depends on fcsg_pkg and filled_circle_span_generator_assert.svh
//
// usage
//   one command item enters on the s_axis channel: center column, center row,
//   radius and color. the block walks the midpoint circle (error term seeded
//   with radius/16) and sends four horizontal span items per iteration on the
//   m_axis channel, the last span of a circle flagged by m_axis_tlast.
//   spans are clipped to the window; a span wholly outside still comes out,
//   with tuser (visible) low and row and columns zero.
// timing
//   a taken command puts the sequencer in ST_RUN; from there spans enter the
//   output register one per cycle while the receiver takes them. one span
//   calculator (row add, two column adds, clip compares) is reused for each of
//   the four spans of an iteration, and the error update rides on the fourth.
//   a circle of n iterations gives 4n spans, n = about 0.71*radius + 1
//   (at most 60 spans, 15 iterations, for the largest radius); the next
//   command is taken once the final span is in the output register.
// reset and stall
//   rst_ni clears the sequencer and drops m_axis_tvalid. when the receiver
//   stalls the output register holds its span and the sequencer waits.
module filled_circle_span_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // center_x[12:0], center_y[25:13], radius[30:26], color[54:31], zero[55]
  input  logic [fcsg_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // row[9:0], x_start[19:10], x_end[29:20], span_color[53:30], zero[55:54]
  output logic [fcsg_pkg::OutDataW-1:0] m_axis_tdata,
  // visible[0]
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);
  import fcsg_pkg::*;

  `include "filled_circle_span_generator_assert.svh"

  localparam logic [4:0]        MaxRad  = 5'(MaxRadius);
  localparam logic signed [13:0] WinW   = 14'(WindowWidth);
  localparam logic signed [13:0] WinH   = 14'(WindowHeight);
  localparam logic [IterW-1:0]  LastIt  = IterW'(MaxIters - 1);

  // command fields
  logic signed [12:0] in_x, in_y;
  logic [4:0]         in_r, r_sat;
  logic [23:0]        in_color;

  // sequencer and circle state
  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic signed [12:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [5:0]  outer_q, outer_d;   // goes below zero only when a circle ends
  logic [4:0]         inner_q, inner_d;
  logic [7:0]         err_q, err_d;
  logic [IterW-1:0]   iter_q, iter_d;
  logic [23:0]        color_q, color_d;

  // output register
  logic        ovalid_q, ovalid_d;
  logic [9:0]  row_q, row_d, xs_q, xs_d, xe_q, xe_d;
  logic        vis_q, vis_d, olast_q, olast_d;
  logic [23:0] ocolor_q, ocolor_d;

  // shared span unit
  logic [4:0]         off, half;
  logic               row_sub;
  logic signed [13:0] cx_w, cy_w, off_w, half_w, row_w, xs_w, xe_w;
  logic               vis;

  // iteration update
  logic [4:0]         inner_n;
  logic [8:0]         err_sum;
  logic signed [9:0]  err_diff;
  logic signed [5:0]  outer_n;
  logic [7:0]         err_n;
  logic               circle_done;

  logic cmd_take, advance;

  assign in_x     = s_axis_tdata[12:0];
  assign in_y     = s_axis_tdata[25:13];
  assign in_r     = s_axis_tdata[30:26];
  assign in_color = s_axis_tdata[54:31];
  assign r_sat    = (in_r > MaxRad) ? MaxRad : in_r;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cmd_take      = s_axis_tvalid && s_axis_tready;
  // while running, a new span is made whenever the output register is free or being emptied
  assign advance       = (state_q == ST_RUN) && (!ovalid_q || m_axis_tready);

  // pick row offset and half width for the current phase
  always_comb begin
    case (phase_q)
      PH_ROW_PLUS_INNER: begin
        off = inner_q; half = outer_q[4:0]; row_sub = 1'b0;
      end
      PH_ROW_MINUS_INNER: begin
        off = inner_q; half = outer_q[4:0]; row_sub = 1'b1;
      end
      PH_ROW_PLUS_OUTER: begin
        off = outer_q[4:0]; half = inner_q; row_sub = 1'b0;
      end
      PH_ROW_MINUS_OUTER: begin
        off = outer_q[4:0]; half = inner_q; row_sub = 1'b1;
      end
      default: begin
        off = inner_q; half = outer_q[4:0]; row_sub = 1'b0;
      end
    endcase
  end

  assign cx_w   = {cx_q[12], cx_q};
  assign cy_w   = {cy_q[12], cy_q};
  assign off_w  = $signed({9'b0, off});
  assign half_w = $signed({9'b0, half});
  assign row_w  = row_sub ? (cy_w - off_w) : (cy_w + off_w);
  assign xs_w   = cx_w - half_w;
  assign xe_w   = cx_w + half_w;
  assign vis    = (row_w >= 14'sd0) && (row_w < WinH) && (xe_w >= 14'sd0) && (xs_w < WinW);

  // midpoint step applied after the fourth span
  assign inner_n  = inner_q + 5'd1;
  assign err_sum  = {1'b0, err_q} + {4'b0, inner_n};
  assign err_diff = $signed({1'b0, err_sum}) - $signed({4'b0, outer_q});
  assign outer_n  = (err_diff >= 10'sd0) ? (outer_q - 6'sd1) : outer_q;
  assign err_n    = (err_diff >= 10'sd0) ? err_diff[7:0] : err_sum[7:0];
  assign circle_done = ($signed({1'b0, inner_n}) > outer_n) || (iter_q == LastIt);

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    outer_d  = outer_q;
    inner_d  = inner_q;
    err_d    = err_q;
    iter_d   = iter_q;
    color_d  = color_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    row_d    = row_q;
    xs_d     = xs_q;
    xe_d     = xe_q;
    vis_d    = vis_q;
    olast_d  = olast_q;
    ocolor_d = ocolor_q;

    if (cmd_take) begin
      state_d = ST_RUN;
      phase_d = PH_ROW_PLUS_INNER;
      cx_d    = in_x;
      cy_d    = in_y;
      outer_d = $signed({1'b0, r_sat});
      inner_d = 5'd0;
      err_d   = {3'b0, r_sat >> ErrShift};
      iter_d  = '0;
      color_d = in_color;
    end

    if (advance) begin
      ovalid_d = 1'b1;
      vis_d    = vis;
      ocolor_d = color_q;
      olast_d  = 1'b0;
      if (vis) begin
        row_d = row_w[9:0];
        xs_d  = (xs_w < 14'sd0) ? 10'd0 : xs_w[9:0];
        xe_d  = (xe_w > (WinW - 14'sd1)) ? 10'(WindowWidth - 1) : xe_w[9:0];
      end else begin
        row_d = 10'd0;
        xs_d  = 10'd0;
        xe_d  = 10'd0;
      end
      if (phase_q == PH_ROW_MINUS_OUTER) begin
        inner_d = inner_n;
        outer_d = outer_n;
        err_d   = err_n;
        iter_d  = iter_q + IterW'(1);
        phase_d = PH_ROW_PLUS_INNER;
        if (circle_done) begin
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end else begin
        phase_d = phase_e'(phase_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_ROW_PLUS_INNER;
      ovalid_q <= 1'b0;
      cx_q     <= '0;
      cy_q     <= '0;
      outer_q  <= '0;
      inner_q  <= '0;
      err_q    <= '0;
      iter_q   <= '0;
      color_q  <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      outer_q  <= outer_d;
      inner_q  <= inner_d;
      err_q    <= err_d;
      iter_q   <= iter_d;
      color_q  <= color_d;
    end
  end

  // span payload, no reset needed
  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    xs_q     <= xs_d;
    xe_q     <= xe_d;
    vis_q    <= vis_d;
    olast_q  <= olast_d;
    ocolor_q <= ocolor_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {2'b0, ocolor_q, xe_q, xs_q, row_q};
  assign m_axis_tuser  = vis_q;
  assign m_axis_tlast  = olast_q;

  // iteration only runs while the outer offset has not passed the inner one
  `FCSG_ASSERT(a_loop_bound, clk_i, rst_ni, (state_q == ST_RUN) |-> ($signed({1'b0, inner_q}) <= outer_q))
  // a taken command restarts the sequencer at the first phase
  `FCSG_ASSERT(a_cmd_start, clk_i, rst_ni, cmd_take |=> (state_q == ST_RUN && phase_q == PH_ROW_PLUS_INNER && inner_q == 5'd0))
  // invisible spans carry zero coordinates
  `FCSG_ASSERT(a_invis_zero, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[29:0] == 30'd0))
  // a visible span never runs backward
  `FCSG_ASSERT(a_vis_order, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser) |-> (xs_q <= xe_q))
  // error term stays small during a circle
  `FCSG_ASSERT_ALWAYS(a_err_small, clk_i, (state_q == ST_RUN) |-> (err_q < 8'd64))

endmodule

FILE: dv/tb.sv
// testbench for filled_circle_span_generator: directed and random circle commands
// depends on fcsg_pkg and the block's rtl; spans are checked against an in-bench predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcsg_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int RandomItems = 500;
  localparam int NumProbes = 23;

  typedef struct packed {
    logic signed [12:0] center_x;
    logic signed [12:0] center_y;
    logic [4:0]         radius;
    logic [23:0]        color;
  } circle_cmd_t;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  x_start;
    logic [9:0]  x_end;
    logic        visible;
    logic [23:0] color;
    logic        last;
  } span_t;

  // directed row: command, and for one-pixel circles the span all four items share
  typedef struct packed {
    logic signed [12:0] cx;
    logic signed [12:0] cy;
    logic [4:0]         rad;
    logic [23:0]        col;
    logic               known;
    logic               k_vis;
    logic [9:0]         k_row;
    logic [9:0]         k_col;
  } probe_t;

  localparam probe_t Probes [NumProbes] = '{
    // zero radius, spans read off directly
    '{0, 0, 0, 24'h000000, 1, 1, 0, 0},
    '{1023, 1023, 0, 24'hFFFFFF, 1, 1, 1023, 1023},
    '{10, 1023, 0, 24'h5A5A5A, 1, 1, 1023, 10},
    '{-4096, -4096, 0, 24'h123456, 1, 0, 0, 0},
    '{4095, 4095, 0, 24'hABCDEF, 1, 0, 0, 0},
    '{1024, 10, 0, 24'h0F0F0F, 1, 0, 0, 0},
    '{10, -1, 0, 24'hF0F0F0, 1, 0, 0, 0},
    // saturation around the maximum radius, then radii near the error divisor and tiny ones
    '{512, 512, 31, 24'h800001, 0, 0, 0, 0},
    '{512, 512, 20, 24'h00FF00, 0, 0, 0, 0},
    '{512, 512, 21, 24'hFF0000, 0, 0, 0, 0},
    '{700, 300, 16, 24'h0000FF, 0, 0, 0, 0},
    '{700, 300, 15, 24'h111111, 0, 0, 0, 0},
    '{300, 700, 1, 24'h222222, 0, 0, 0, 0},
    '{300, 700, 2, 24'h333333, 0, 0, 0, 0},
    // clipping on every window edge
    '{0, 0, 20, 24'h444444, 0, 0, 0, 0},
    '{1023, 1023, 20, 24'h555555, 0, 0, 0, 0},
    '{-10, 500, 15, 24'h666666, 0, 0, 0, 0},
    '{1030, 500, 15, 24'h777777, 0, 0, 0, 0},
    '{500, -5, 10, 24'h888888, 0, 0, 0, 0},
    '{500, 1028, 10, 24'h999999, 0, 0, 0, 0},
    '{-20, -20, 20, 24'hAAAAAA, 0, 0, 0, 0},
    // far off screen, every span hidden
    '{-4096, 4095, 31, 24'hCCCCCC, 0, 0, 0, 0},
    '{4095, -4096, 31, 24'hDDDDDD, 0, 0, 0, 0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  span_t pending_spans [$];
  int    mismatches   = 0;
  int    hold_off     = 0;
  int    quiet_cycles = 0;
  bit    jitter       = 1'b1;

  filled_circle_span_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // clip one span to the window; hidden spans carry zero coordinates
  function automatic span_t clip_span(int row, int lo, int hi, logic [23:0] color);
    span_t s;
    s = '0;
    s.color = color;
    if (row >= 0 && row < WindowHeight && hi >= 0 && lo < WindowWidth) begin
      if (lo < 0) lo = 0;
      if (hi > WindowWidth - 1) hi = WindowWidth - 1;
      s.row     = row[9:0];
      s.x_start = lo[9:0];
      s.x_end   = hi[9:0];
      s.visible = 1'b1;
    end
    return s;
  endfunction

  // walk the midpoint circle and queue every span it produces, in output order
  function automatic void trace_circle(circle_cmd_t c);
    int     cx, cy, major, minor, decision, steps;
    int     row, lo, hi;
    phase_e ph;
    span_t  s;
    cx       = int'(c.center_x);
    cy       = int'(c.center_y);
    major    = (int'(c.radius) > MaxRadius) ? MaxRadius : int'(c.radius);
    decision = major / ErrDivisor;
    minor    = 0;
    steps    = 0;
    while (major >= minor && steps < MaxIters) begin
      for (int p = 0; p < 4; p++) begin
        ph = phase_e'(p);
        case (ph)
          PH_ROW_PLUS_INNER: begin
            row = cy + minor; lo = cx - major; hi = cx + major;
          end
          PH_ROW_MINUS_INNER: begin
            row = cy - minor; lo = cx - major; hi = cx + major;
          end
          PH_ROW_PLUS_OUTER: begin
            row = cy + major; lo = cx - minor; hi = cx + minor;
          end
          default: begin
            row = cy - major; lo = cx - minor; hi = cx + minor;
          end
        endcase
        pending_spans.push_back(clip_span(row, lo, hi, c.color));
      end
      minor++;
      decision += minor;
      if (decision - major >= 0) begin
        decision -= major;
        major--;
      end
      steps++;
    end
    s = pending_spans.pop_back();
    s.last = 1'b1;
    pending_spans.push_back(s);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t span %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // present one command, with an occasional idle burst in front, until taken
  task automatic send_circle(input circle_cmd_t c);
    if (jitter && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, c.color, c.radius, c.center_y, c.center_x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold off new commands until every queued span has come out
  task automatic drain_spans();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_spans.size() != 0);
  endtask

  // receiver: ready, with random stall bursts while jitter is on
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off      <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (jitter && $urandom_range(0, 5) == 0) begin
      hold_off      <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // span checker
  always @(posedge clk_i) begin
    span_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row     = m_axis_tdata[9:0];
      got.x_start = m_axis_tdata[19:10];
      got.x_end   = m_axis_tdata[29:20];
      got.color   = m_axis_tdata[53:30];
      got.visible = m_axis_tuser;
      got.last    = m_axis_tlast;
      if (pending_spans.size() == 0) begin
        $display("%0t span with none pending: expected nothing, actual row %0d x %0d..%0d",
                 $time, got.row, got.x_start, got.x_end);
        mismatches++;
      end else begin
        want = pending_spans.pop_front();
        check_field("row", int'(want.row), int'(got.row));
        check_field("x_start", int'(want.x_start), int'(got.x_start));
        check_field("x_end", int'(want.x_end), int'(got.x_end));
        check_field("visible", int'(want.visible), int'(got.visible));
        check_field("color", int'(want.color), int'(got.color));
        check_field("last", int'(want.last), int'(got.last));
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    circle_cmd_t c;
    probe_t      p;
    span_t       s;
    int          base, offs;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed commands
    for (int i = 0; i < NumProbes; i++) begin
      p = Probes[i];
      c.center_x = p.cx;
      c.center_y = p.cy;
      c.radius   = p.rad;
      c.color    = p.col;
      send_circle(c);
      if (p.known) begin
        for (int k = 0; k < 4; k++) begin
          s         = '0;
          s.row     = p.k_row;
          s.x_start = p.k_col;
          s.x_end   = p.k_col;
          s.visible = p.k_vis;
          s.color   = p.col;
          s.last    = (k == 3);
          pending_spans.push_back(s);
        end
      end else begin
        trace_circle(c);
      end
    end
    drain_spans();

    // random commands, mostly near or inside the window
    for (int n = 0; n < RandomItems; n++) begin
      jitter = (n < RandomItems - 70) && ((n / 40) % 3 != 2);
      for (int a = 0; a < 2; a++) begin
        case ($urandom_range(0, 9))
          0: offs = $signed(13'($urandom));
          1, 2: begin
            base = $urandom_range(0, 1) ? 1023 : 0;
            offs = base + int'($urandom_range(0, 80)) - 40;
          end
          default: offs = int'($urandom_range(0, 1023));
        endcase
        if (a == 0) c.center_x = 13'(offs);
        else c.center_y = 13'(offs);
      end
      c.radius = 5'($urandom_range(0, 31));
      c.color  = 24'($urandom);
      send_circle(c);
      trace_circle(c);
      if (n == RandomItems / 2) drain_spans();
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_spans.size() != 0);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
